FILE: rtl/core/servo_slew_radar_sweep_assert.svh
// ----------------------------------------------------------------------------
// servo slew radar sweep assertion macros
// concurrent assertion shorthands clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef SERVO_SLEW_RADAR_SWEEP_ASSERT_SVH
`define SERVO_SLEW_RADAR_SWEEP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SSRS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SSRS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/ssrs_pkg.sv
// ----------------------------------------------------------------------------
// ssrs_pkg
// shared types and constants of the servo slew radar sweep block
// ----------------------------------------------------------------------------
`default_nettype none

package ssrs_pkg;

   typedef logic [1:0]         action_type;
   typedef logic [1:0]         servo_type;
   typedef logic [2:0]         csr_index_type;
   typedef logic [7:0]         csr_data_type;
   typedef logic signed [7:0]  cmd_type;
   typedef logic signed [15:0] pos_type;
   typedef logic [12:0]        compare_type;

   localparam action_type ACT_TARGET = 2'd0;
   localparam action_type ACT_RADAR  = 2'd1;
   localparam action_type ACT_TICK   = 2'd2;

   localparam servo_type SERVO_PAN   = 2'd0;
   localparam servo_type SERVO_TILT  = 2'd1;
   localparam servo_type SERVO_SWEEP = 2'd2;

   localparam int SERVO_COUNT = 3;

   localparam csr_index_type REG_PAN_ADJUST   = 3'd0;
   localparam csr_index_type REG_TILT_ADJUST  = 3'd1;
   localparam csr_index_type REG_RADAR_ADJUST = 3'd2;
   localparam csr_index_type REG_PAN_INVERT   = 3'd3;
   localparam csr_index_type REG_TILT_INVERT  = 3'd4;
   localparam csr_index_type REG_RADAR_STILL  = 3'd5;

   // floor(m/7) == (m * RECIP_SEVEN) >> SEVEN_SHIFT for every m below 2**18
   localparam logic [18:0] RECIP_SEVEN = 19'd299594;
   localparam int          SEVEN_SHIFT = 21;

   // compare = (PULSE_SPAN * (pos + 32768)) / 65536 + pulse low - 1
   localparam logic [18:0] PULSE_SPAN  = 19'd3277;
   localparam compare_type PULSE_FLOOR = 13'd3275;

endpackage

`default_nettype wire

FILE: rtl/core/ssrs_if.sv
// ----------------------------------------------------------------------------
// ssrs_if
// valid/ready channels of the servo slew radar sweep block
// ----------------------------------------------------------------------------
`default_nettype none

interface ssrs_req_if;
   logic                  valid;
   logic                  ready;
   ssrs_pkg::action_type  action;
   ssrs_pkg::servo_type   servo_sel;
   ssrs_pkg::cmd_type     cmd_value;

   modport source (output valid, action, servo_sel, cmd_value, input ready);
   modport sink   (input valid, action, servo_sel, cmd_value, output ready);
endinterface

interface ssrs_rsp_if;
   logic                  valid;
   logic                  ready;
   ssrs_pkg::servo_type   channel;
   ssrs_pkg::compare_type compare_value;
   ssrs_pkg::pos_type     position;
   logic                  changed;
   ssrs_pkg::pos_type     sweep_position;
   logic                  sweep_down;
   logic                  last;

   modport source (output valid, channel, compare_value, position, changed,
                   sweep_position, sweep_down, last, input ready);
   modport sink   (input valid, channel, compare_value, position, changed,
                   sweep_position, sweep_down, last, output ready);
endinterface

interface ssrs_csr_if;
   logic                    valid;
   logic                    ready;
   ssrs_pkg::csr_index_type index;
   ssrs_pkg::csr_data_type  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/servo_slew_radar_sweep.sv
// ----------------------------------------------------------------------------
// servo_slew_radar_sweep
// three servo channels slewed toward their targets, radar target from a
// bouncing sweep, one shared multiplier under a small sequencer
// ----------------------------------------------------------------------------
//  channel   direction  fields
//  req_bus   in         action, servo_sel, cmd_value
//  rsp_bus   out        channel, compare_value, position, changed,
//                       sweep_position, sweep_down, last
//  csr_bus   in         index, data (always ready)
//
//  radar command: handled at accept; target command: accept, two multiplier
//  passes for the divisions by seven, target write; tick: accept, bounce,
//  move, three division steps, then slew, scale, emit per channel, with each
//  emit held by any rsp stall; the passes share one 18x19 multiplier.
//  req ready is high only while the sequencer is idle.
//  reset is synchronous; a pending result register may still be draining
//  when the next transaction is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_slew_radar_sweep #(
   parameter int SLEW_STEP = 512
) (
   input  logic         clock,
   input  logic         reset,
   ssrs_req_if.sink     req_bus,
   ssrs_rsp_if.source   rsp_bus,
   ssrs_csr_if.sink     csr_bus
);

   localparam int          JUMP_LIMIT = SLEW_STEP * 20;
   localparam logic [17:0] JUMP_MAG   = 18'(JUMP_LIMIT);
   localparam logic [16:0] STEP_MAG   = 17'(SLEW_STEP);
   localparam logic [15:0] STEP_POS   = 16'(SLEW_STEP);
   localparam logic [1:0]  LAST_CH    = 2'(ssrs_pkg::SERVO_COUNT - 1);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_BOUNCE = 4'd1;
   localparam logic [3:0] ST_MOVE   = 4'd2;
   localparam logic [3:0] ST_DIV_A  = 4'd3;
   localparam logic [3:0] ST_DIV_B  = 4'd4;
   localparam logic [3:0] ST_DIV_C  = 4'd5;
   localparam logic [3:0] ST_SLEW   = 4'd6;
   localparam logic [3:0] ST_SCALE  = 4'd7;
   localparam logic [3:0] ST_EMIT   = 4'd8;

   // sequencer
   logic [3:0]          state_ff, state_in;
   logic                tick_ff, tick_in;
   logic [1:0]          sel_ff, sel_in;
   ssrs_pkg::cmd_type   value_ff, value_in;
   logic                neg_ff, neg_in;
   logic signed [16:0]  acc_ff, acc_in;
   logic [36:0]         prod_ff, prod_in;
   logic [1:0]          ch_ff, ch_in;
   logic                changed_ff, changed_in;

   // servo and sweep state
   ssrs_pkg::pos_type   target_ff [ssrs_pkg::SERVO_COUNT];
   ssrs_pkg::pos_type   target_in [ssrs_pkg::SERVO_COUNT];
   ssrs_pkg::pos_type   current_ff [ssrs_pkg::SERVO_COUNT];
   ssrs_pkg::pos_type   current_in [ssrs_pkg::SERVO_COUNT];
   ssrs_pkg::pos_type   sweep_pos_ff, sweep_pos_in;
   ssrs_pkg::pos_type   sweep_speed_ff, sweep_speed_in;
   logic                sweep_down_ff, sweep_down_in;

   // configuration
   ssrs_pkg::cmd_type   pan_adj_ff, pan_adj_in;
   ssrs_pkg::cmd_type   tilt_adj_ff, tilt_adj_in;
   ssrs_pkg::cmd_type   radar_adj_ff, radar_adj_in;
   logic                pan_inv_ff, pan_inv_in;
   logic                tilt_inv_ff, tilt_inv_in;
   ssrs_pkg::cmd_type   still_ff, still_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic [1:0]            out_channel_ff, out_channel_in;
   ssrs_pkg::compare_type out_compare_ff, out_compare_in;
   ssrs_pkg::pos_type     out_position_ff, out_position_in;
   logic                  out_changed_ff, out_changed_in;
   ssrs_pkg::pos_type     out_sweep_pos_ff, out_sweep_pos_in;
   logic                  out_sweep_down_ff, out_sweep_down_in;
   logic                  out_last_ff, out_last_in;

   // datapath
   logic                req_fire;
   logic                slot_free;
   ssrs_pkg::cmd_type   adj_sel;
   logic                inv_sel;
   logic signed [18:0]  value_ext, adj_ext, main_dvd, trim_dvd, dvd;
   logic [17:0]         dvd_mag;
   logic [17:0]         mul_a;
   logic [18:0]         mul_b;
   logic [15:0]         quot;
   logic signed [16:0]  quot_s, sum_s, tgt_s;
   logic signed [17:0]  pos18, spd18, up_lim, dn_lim;
   ssrs_pkg::pos_type   sweep_next;
   ssrs_pkg::pos_type   cur, tgt, gap, step, slewed;
   logic [16:0]         gap_mag;
   logic                slew_move;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_fire      = req_bus.valid && (state_ff == ST_IDLE);
   assign slot_free     = !out_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.channel        = out_channel_ff;
   assign rsp_bus.compare_value  = out_compare_ff;
   assign rsp_bus.position       = out_position_ff;
   assign rsp_bus.changed        = out_changed_ff;
   assign rsp_bus.sweep_position = out_sweep_pos_ff;
   assign rsp_bus.sweep_down     = out_sweep_down_ff;
   assign rsp_bus.last           = out_last_ff;

   // trim and invert of the servo being targeted
   always_comb begin
      case (sel_ff)
         ssrs_pkg::SERVO_PAN: begin
            adj_sel = pan_adj_ff;
            inv_sel = pan_inv_ff;
         end
         ssrs_pkg::SERVO_TILT: begin
            adj_sel = tilt_adj_ff;
            inv_sel = tilt_inv_ff;
         end
         default: begin
            adj_sel = radar_adj_ff;
            inv_sel = 1'b0;
         end
      endcase
   end

   // dividends 6*v*256 and adj*256, divided by seven as magnitude and sign
   assign value_ext = 19'(value_ff);
   assign adj_ext   = 19'(adj_sel);
   assign main_dvd  = (value_ext <<< 10) + (value_ext <<< 9);
   assign trim_dvd  = adj_ext <<< 8;
   assign dvd       = (state_ff == ST_DIV_A) ? main_dvd : trim_dvd;
   assign dvd_mag   = dvd[18] ? 18'(-dvd) : dvd[17:0];

   assign quot   = prod_ff[ssrs_pkg::SEVEN_SHIFT +: 16];
   assign quot_s = neg_ff ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
   assign sum_s  = acc_ff + quot_s;
   assign tgt_s  = inv_sel ? -sum_s : sum_s;

   // shared multiplier operands
   always_comb begin
      if (state_ff == ST_SCALE) begin
         mul_a = {2'b00, current_ff[ch_ff] ^ 16'h8000};
         mul_b = ssrs_pkg::PULSE_SPAN;
      end else begin
         mul_a = dvd_mag;
         mul_b = ssrs_pkg::RECIP_SEVEN;
      end
   end

   // sweep bounce limits at full precision
   assign pos18      = 18'(sweep_pos_ff);
   assign spd18      = 18'(sweep_speed_ff);
   assign up_lim     = 18'sd32767 - spd18;
   assign dn_lim     = spd18 - 18'sd32768;
   assign sweep_next = sweep_down_ff ? sweep_pos_ff - sweep_speed_ff
                                     : sweep_pos_ff + sweep_speed_ff;

   // slew of the channel in hand
   assign cur       = current_ff[ch_ff];
   assign tgt       = target_ff[ch_ff];
   assign gap       = tgt - cur;
   assign gap_mag   = gap[15] ? 17'(-$signed({gap[15], gap})) : {1'b0, gap};
   assign step      = (gap_mag >= STEP_MAG) ? STEP_POS : 16'd1;
   assign slew_move = (gap != 16'sd0);
   always_comb begin
      if ({1'b0, gap_mag} > JUMP_MAG) begin
         slewed = tgt;
      end else if (!slew_move) begin
         slewed = cur;
      end else if (gap[15]) begin
         slewed = cur - step;
      end else begin
         slewed = cur + step;
      end
   end

   always_comb begin
      state_in       = state_ff;
      tick_in        = tick_ff;
      sel_in         = sel_ff;
      value_in       = value_ff;
      neg_in         = neg_ff;
      acc_in         = acc_ff;
      prod_in        = prod_ff;
      ch_in          = ch_ff;
      changed_in     = changed_ff;
      target_in      = target_ff;
      current_in     = current_ff;
      sweep_pos_in   = sweep_pos_ff;
      sweep_speed_in = sweep_speed_ff;
      sweep_down_in  = sweep_down_ff;

      pan_adj_in   = pan_adj_ff;
      tilt_adj_in  = tilt_adj_ff;
      radar_adj_in = radar_adj_ff;
      pan_inv_in   = pan_inv_ff;
      tilt_inv_in  = tilt_inv_ff;
      still_in     = still_ff;

      out_valid_in      = out_valid_ff && !rsp_bus.ready;
      out_channel_in    = out_channel_ff;
      out_compare_in    = out_compare_ff;
      out_position_in   = out_position_ff;
      out_changed_in    = out_changed_ff;
      out_sweep_pos_in  = out_sweep_pos_ff;
      out_sweep_down_in = out_sweep_down_ff;
      out_last_in       = out_last_ff;

      if (csr_bus.valid) begin
         case (csr_bus.index)
            ssrs_pkg::REG_PAN_ADJUST:   pan_adj_in   = csr_bus.data;
            ssrs_pkg::REG_TILT_ADJUST:  tilt_adj_in  = csr_bus.data;
            ssrs_pkg::REG_RADAR_ADJUST: radar_adj_in = csr_bus.data;
            ssrs_pkg::REG_PAN_INVERT:   pan_inv_in   = csr_bus.data[0];
            ssrs_pkg::REG_TILT_INVERT:  tilt_inv_in  = csr_bus.data[0];
            ssrs_pkg::REG_RADAR_STILL:  still_in     = csr_bus.data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_bus.action)
                  ssrs_pkg::ACT_TARGET: begin
                     if (req_bus.servo_sel inside {ssrs_pkg::SERVO_PAN, ssrs_pkg::SERVO_TILT,
                                                   ssrs_pkg::SERVO_SWEEP}) begin
                        sel_in   = req_bus.servo_sel;
                        value_in = req_bus.cmd_value;
                        tick_in  = 1'b0;
                        state_in = ST_DIV_A;
                     end
                  end
                  ssrs_pkg::ACT_RADAR: begin
                     if (req_bus.cmd_value == still_ff) begin
                        sweep_speed_in = 16'sd0;
                        sweep_pos_in   = 16'sd0;
                     end else begin
                        sweep_speed_in = {req_bus.cmd_value[7], req_bus.cmd_value, 7'b0};
                     end
                  end
                  ssrs_pkg::ACT_TICK: begin
                     tick_in  = 1'b1;
                     state_in = ST_BOUNCE;
                  end
                  default: ;
               endcase
            end
         end
         ST_BOUNCE: begin
            if (sweep_down_ff) begin
               if (pos18 <= dn_lim) begin
                  sweep_pos_in  = 16'sh8000;
                  sweep_down_in = 1'b0;
               end
            end else if (pos18 >= up_lim) begin
               sweep_pos_in  = 16'sh7fff;
               sweep_down_in = 1'b1;
            end
            state_in = ST_MOVE;
         end
         ST_MOVE: begin
            sweep_pos_in = sweep_next;
            // radar target follows the sweep's upper byte
            sel_in       = ssrs_pkg::SERVO_SWEEP;
            value_in     = sweep_next[15:8];
            state_in     = ST_DIV_A;
         end
         ST_DIV_A: begin
            prod_in  = 37'(mul_a) * 37'(mul_b);
            neg_in   = dvd[18];
            state_in = ST_DIV_B;
         end
         ST_DIV_B: begin
            acc_in   = quot_s;
            prod_in  = 37'(mul_a) * 37'(mul_b);
            neg_in   = dvd[18];
            state_in = ST_DIV_C;
         end
         ST_DIV_C: begin
            target_in[sel_ff] = tgt_s[15:0];
            ch_in             = 2'd0;
            state_in          = tick_ff ? ST_SLEW : ST_IDLE;
         end
         ST_SLEW: begin
            current_in[ch_ff] = slewed;
            changed_in        = slew_move;
            state_in          = ST_SCALE;
         end
         ST_SCALE: begin
            prod_in  = 37'(mul_a) * 37'(mul_b);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               out_valid_in      = 1'b1;
               out_channel_in    = ch_ff;
               out_compare_in    = 13'(prod_ff[27:16]) + ssrs_pkg::PULSE_FLOOR;
               out_position_in   = cur;
               out_changed_in    = changed_ff;
               out_sweep_pos_in  = sweep_pos_ff;
               out_sweep_down_in = sweep_down_ff;
               out_last_in       = (ch_ff == LAST_CH);
               if (ch_ff == LAST_CH) begin
                  tick_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  ch_in    = ch_ff + 2'd1;
                  state_in = ST_SLEW;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         tick_ff        <= 1'b0;
         out_valid_ff   <= 1'b0;
         sweep_pos_ff   <= 16'sd0;
         sweep_speed_ff <= 16'sd512;
         sweep_down_ff  <= 1'b0;
         pan_adj_ff     <= 8'sd0;
         tilt_adj_ff    <= 8'sd0;
         radar_adj_ff   <= 8'sd0;
         pan_inv_ff     <= 1'b0;
         tilt_inv_ff    <= 1'b0;
         still_ff       <= 8'sd0;
         for (int i = 0; i < ssrs_pkg::SERVO_COUNT; i++) begin
            target_ff[i]  <= 16'sd0;
            current_ff[i] <= 16'sd0;
         end
      end else begin
         state_ff       <= state_in;
         tick_ff        <= tick_in;
         out_valid_ff   <= out_valid_in;
         sweep_pos_ff   <= sweep_pos_in;
         sweep_speed_ff <= sweep_speed_in;
         sweep_down_ff  <= sweep_down_in;
         pan_adj_ff     <= pan_adj_in;
         tilt_adj_ff    <= tilt_adj_in;
         radar_adj_ff   <= radar_adj_in;
         pan_inv_ff     <= pan_inv_in;
         tilt_inv_ff    <= tilt_inv_in;
         still_ff       <= still_in;
         target_ff      <= target_in;
         current_ff     <= current_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff            <= sel_in;
      value_ff          <= value_in;
      neg_ff            <= neg_in;
      acc_ff            <= acc_in;
      prod_ff           <= prod_in;
      ch_ff             <= ch_in;
      changed_ff        <= changed_in;
      out_channel_ff    <= out_channel_in;
      out_compare_ff    <= out_compare_in;
      out_position_ff   <= out_position_in;
      out_changed_ff    <= out_changed_in;
      out_sweep_pos_ff  <= out_sweep_pos_in;
      out_sweep_down_ff <= out_sweep_down_in;
      out_last_ff       <= out_last_in;
   end

endmodule

`default_nettype wire

FILE: rtl/core/ssrs_checker.sv
// ----------------------------------------------------------------------------
// ssrs_checker
// port-level checks of the servo slew radar sweep block
// ----------------------------------------------------------------------------
`default_nettype none

`include "servo_slew_radar_sweep_assert.svh"

module ssrs_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [1:0]            rsp_channel,
   input ssrs_pkg::compare_type rsp_compare_value,
   input ssrs_pkg::pos_type     rsp_position,
   input logic                  rsp_last
);

   logic [31:0] expect_cmp;

   assign expect_cmp = ((32'd3277 * 32'(rsp_position ^ 16'h8000)) >> 16) + 32'd3275;

   // a stalled result keeps its contents
   `SSRS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_position) && $stable(rsp_compare_value),
      "stalled result changed")

   // compare count tracks the reported position
   `SSRS_ASSERT_SAME(a_cmp_match, rsp_valid,
      rsp_compare_value == expect_cmp[12:0],
      "compare value does not match position")

   // only the radar channel closes a tick
   `SSRS_ASSERT_SAME(a_last_radar, rsp_valid,
      rsp_last == (rsp_channel == ssrs_pkg::SERVO_SWEEP),
      "last flag on wrong channel")

   // while an early channel of a tick is on the output the sequencer is busy
   `SSRS_ASSERT_SAME(a_busy_mid_tick, rsp_valid && !rsp_last,
      !req_ready,
      "input ready in the middle of a tick")

endmodule

bind servo_slew_radar_sweep ssrs_checker u_ssrs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_channel       (rsp_bus.channel),
   .rsp_compare_value (rsp_bus.compare_value),
   .rsp_position      (rsp_bus.position),
   .rsp_last          (rsp_bus.last)
);

`default_nettype wire
